// File: src/pasmu_pkg.sv
`timescale 1ns / 1ps

package pasmu_pkg;

	// Capacity and fixed-point format.
	localparam int MAX_TERMS = 32;
	localparam int FRAC_BITS = 16;

	localparam int COEF_W = 32;
	localparam int OUT_W  = 48;
	localparam int PROD_W = 2 * COEF_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int LEN_W  = $clog2(MAX_TERMS + 1);
	localparam int SLOT_W = $clog2(2 * MAX_TERMS);

	// Request type codes.
	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_START  = 2'd2;

	// Operation codes; any other code multiplies.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [1:0]               op_select;
		logic signed [COEF_W-1:0] coef_in;
	} req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] coef_out;
		logic                    is_last;
		logic                    saturated;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic                    wr_a;
		logic                    wr_b;
		logic [IDX_W-1:0]        wr_addr;
		logic signed [COEF_W-1:0] wr_data;
		logic                    issue;
		logic [IDX_W-1:0]        a_addr;
		logic [IDX_W-1:0]        b_addr;
		logic                    a_zero;
		logic                    b_zero;
		logic                    first;
		logic                    last;
		logic                    is_last;
		logic [1:0]              op;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic advance;
		logic done;
	} stat_t;

endpackage

// File: src/pasmu_ctrl.sv
`timescale 1ns / 1ps

module pasmu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pasmu_pkg::req_t req_data,
	input  pasmu_pkg::stat_t stat,
	output pasmu_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	logic [pasmu_pkg::LEN_W-1:0]  len_a_q, len_b_q;
	logic [pasmu_pkg::SLOT_W-1:0] la_q, lb_q, n_q, s_q, j_q;
	logic                         a_empty_q, b_empty_q, mul_q;
	logic [1:0]                   op_q;

	logic                         accept;
	logic                         a_room, b_room;
	logic [pasmu_pkg::SLOT_W-1:0] la_eff, lb_eff, n_start;
	logic [pasmu_pkg::SLOT_W-1:0] a_off, b_off, j_hi, s_nxt, j_lo_nxt, k_idx;
	logic [pasmu_pkg::SLOT_W-1:0] a_add_idx, b_add_idx;
	logic                         step_last;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign a_room    = len_a_q < pasmu_pkg::LEN_W'(pasmu_pkg::MAX_TERMS);
	assign b_room    = len_b_q < pasmu_pkg::LEN_W'(pasmu_pkg::MAX_TERMS);

	// An empty operand behaves as a single zero term.
	assign la_eff = (len_a_q == '0) ? pasmu_pkg::SLOT_W'(1) : pasmu_pkg::SLOT_W'(len_a_q);
	assign lb_eff = (len_b_q == '0) ? pasmu_pkg::SLOT_W'(1) : pasmu_pkg::SLOT_W'(len_b_q);

	always_comb begin
		case (req_data.op_select)
			pasmu_pkg::OP_ADD, pasmu_pkg::OP_SUB: begin
				n_start = (la_eff > lb_eff) ? la_eff : lb_eff;
			end
			default: begin
				n_start = la_eff + lb_eff - pasmu_pkg::SLOT_W'(1);
			end
		endcase
	end

	// Add and subtract align terms by degree against the longer operand.
	assign a_off     = n_q - la_q;
	assign b_off     = n_q - lb_q;
	assign a_add_idx = s_q - a_off;
	assign b_add_idx = s_q - b_off;

	// Multiply: slot s sums first[j] * second[s - j] over the valid j range.
	assign k_idx    = s_q - j_q;
	assign j_hi     = (s_q < la_q) ? s_q : (la_q - pasmu_pkg::SLOT_W'(1));
	assign s_nxt    = s_q + pasmu_pkg::SLOT_W'(1);
	assign j_lo_nxt = (s_nxt >= lb_q) ? (s_nxt - lb_q + pasmu_pkg::SLOT_W'(1)) : '0;
	assign step_last = mul_q ? (j_q == j_hi) : 1'b1;

	always_comb begin
		cmd.wr_a    = accept && (req_data.req_type == pasmu_pkg::REQ_LOAD_A) && a_room;
		cmd.wr_b    = accept && (req_data.req_type == pasmu_pkg::REQ_LOAD_B) && b_room;
		cmd.wr_addr = (req_data.req_type == pasmu_pkg::REQ_LOAD_A) ?
			len_a_q[pasmu_pkg::IDX_W-1:0] : len_b_q[pasmu_pkg::IDX_W-1:0];
		cmd.wr_data = req_data.coef_in;
		cmd.issue   = (state_q == ST_RUN) && stat.advance;
		cmd.first   = mul_q ? (j_q == ((s_q >= lb_q) ? (s_q - lb_q + pasmu_pkg::SLOT_W'(1)) : '0))
			: 1'b1;
		cmd.last    = step_last;
		cmd.is_last = (s_q == n_q - pasmu_pkg::SLOT_W'(1));
		cmd.op      = op_q;
		if (mul_q) begin
			cmd.a_addr = j_q[pasmu_pkg::IDX_W-1:0];
			cmd.b_addr = k_idx[pasmu_pkg::IDX_W-1:0];
			cmd.a_zero = a_empty_q;
			cmd.b_zero = b_empty_q;
		end else begin
			cmd.a_addr = a_add_idx[pasmu_pkg::IDX_W-1:0];
			cmd.b_addr = b_add_idx[pasmu_pkg::IDX_W-1:0];
			cmd.a_zero = a_empty_q || (s_q < a_off);
			cmd.b_zero = b_empty_q || (s_q < b_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_a_q   <= '0;
			len_b_q   <= '0;
			la_q      <= '0;
			lb_q      <= '0;
			n_q       <= '0;
			s_q       <= '0;
			j_q       <= '0;
			a_empty_q <= 1'b0;
			b_empty_q <= 1'b0;
			mul_q     <= 1'b0;
			op_q      <= pasmu_pkg::OP_ADD;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.wr_a) begin
						len_a_q <= len_a_q + pasmu_pkg::LEN_W'(1);
					end
					if (cmd.wr_b) begin
						len_b_q <= len_b_q + pasmu_pkg::LEN_W'(1);
					end
					if (accept && (req_data.req_type == pasmu_pkg::REQ_START)) begin
						la_q      <= la_eff;
						lb_q      <= lb_eff;
						n_q       <= n_start;
						a_empty_q <= (len_a_q == '0);
						b_empty_q <= (len_b_q == '0);
						op_q      <= req_data.op_select;
						mul_q     <= !(req_data.op_select inside {pasmu_pkg::OP_ADD,
							pasmu_pkg::OP_SUB});
						s_q       <= '0;
						j_q       <= '0;
						len_a_q   <= '0;
						len_b_q   <= '0;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.issue) begin
						if (step_last) begin
							if (cmd.is_last) begin
								state_q <= ST_DRAIN;
							end else begin
								s_q <= s_nxt;
								j_q <= j_lo_nxt;
							end
						end else begin
							j_q <= j_q + pasmu_pkg::SLOT_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/pasmu_dp.sv
`timescale 1ns / 1ps

module pasmu_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  pasmu_pkg::cmd_t  cmd,
	output pasmu_pkg::stat_t stat,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output pasmu_pkg::rsp_t  rsp_data
);

	localparam logic signed [pasmu_pkg::SUM_W-1:0] OUT_MAX =
		(pasmu_pkg::SUM_W'(1) <<< (pasmu_pkg::OUT_W - 1)) - pasmu_pkg::SUM_W'(1);
	localparam logic signed [pasmu_pkg::SUM_W-1:0] OUT_MIN = -OUT_MAX - pasmu_pkg::SUM_W'(1);

	logic signed [pasmu_pkg::COEF_W-1:0] mem_a [pasmu_pkg::MAX_TERMS];
	logic signed [pasmu_pkg::COEF_W-1:0] mem_b [pasmu_pkg::MAX_TERMS];

	logic                                advance;

	// Stage 1: registered store reads.
	logic signed [pasmu_pkg::COEF_W-1:0] rd_a_s1, rd_b_s1;
	logic                                valid_s1, a_zero_s1, b_zero_s1;
	logic                                first_s1, last_s1, is_last_s1;
	logic [1:0]                          op_s1;

	// Stage 2: product or sum term.
	logic signed [pasmu_pkg::PROD_W-1:0] term_s2;
	logic                                valid_s2, first_s2, last_s2, is_last_s2;

	logic signed [pasmu_pkg::COEF_W-1:0] a_val, b_val;
	logic signed [pasmu_pkg::PROD_W-1:0] prod, term_d;

	logic signed [pasmu_pkg::OUT_W-1:0]  acc_q, base;
	logic                                sat_q, base_sat, ovf;
	logic signed [pasmu_pkg::SUM_W-1:0]  sum;
	logic signed [pasmu_pkg::OUT_W-1:0]  clamped;

	logic                                rsp_valid_q;
	pasmu_pkg::rsp_t                     rsp_q;

	// The whole pipeline holds while a result waits to be taken.
	assign advance      = !rsp_valid_q || rsp_ready;
	assign stat.advance = advance;
	assign stat.done    = rsp_valid_q && rsp_ready && rsp_q.is_last;

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.wr_b) begin
			mem_b[cmd.wr_addr] <= cmd.wr_data;
		end
		if (advance) begin
			rd_a_s1 <= mem_a[cmd.a_addr];
			rd_b_s1 <= mem_b[cmd.b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_zero_s1  <= cmd.a_zero;
			b_zero_s1  <= cmd.b_zero;
			first_s1   <= cmd.first;
			last_s1    <= cmd.last;
			is_last_s1 <= cmd.is_last;
			op_s1      <= cmd.op;
			term_s2    <= term_d;
			first_s2   <= first_s1;
			last_s2    <= last_s1;
			is_last_s2 <= is_last_s1;
		end
	end

	assign a_val = a_zero_s1 ? '0 : rd_a_s1;
	assign b_val = b_zero_s1 ? '0 : rd_b_s1;
	assign prod  = a_val * b_val;

	always_comb begin
		case (op_s1)
			pasmu_pkg::OP_ADD: term_d = a_val + b_val;
			pasmu_pkg::OP_SUB: term_d = a_val - b_val;
			default:           term_d = prod >>> pasmu_pkg::FRAC_BITS;
		endcase
	end

	// Accumulate with a clamp after every addition; the flag is sticky per slot.
	assign base     = first_s2 ? '0 : acc_q;
	assign base_sat = first_s2 ? 1'b0 : sat_q;
	assign sum      = base + term_s2;

	always_comb begin
		ovf     = 1'b0;
		clamped = sum[pasmu_pkg::OUT_W-1:0];
		if (sum > OUT_MAX) begin
			ovf     = 1'b1;
			clamped = OUT_MAX[pasmu_pkg::OUT_W-1:0];
		end else if (sum < OUT_MIN) begin
			ovf     = 1'b1;
			clamped = OUT_MIN[pasmu_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			acc_q <= clamped;
			sat_q <= base_sat || ovf;
		end
		if (advance && valid_s2 && last_s2) begin
			rsp_q.coef_out  <= clamped;
			rsp_q.is_last   <= is_last_s2;
			rsp_q.saturated <= base_sat || ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			rsp_valid_q <= valid_s2 && last_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: src/polynomial_add_sub_mul_unit_core.sv
`timescale 1ns / 1ps
// Load requests are taken while the unit is idle. A start request for add or subtract runs
// n = max(la, lb) steps, and for multiply la * lb multiply-accumulate steps on the one shared
// multiplier, one step per cycle while the consumer takes results; each result passes the
// store-read, term and result registers. A new request is taken once the last result is gone.
// Reset clears both lengths, the controller and every valid flag; the stores are undefined.
module polynomial_add_sub_mul_unit_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pasmu_pkg::req_t req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pasmu_pkg::rsp_t rsp_data
);

	// The controller walks the result slots and, for multiply, the terms of each slot.
	// Each step carries its store addresses and the first/last marks of its slot.
	pasmu_pkg::cmd_t  cmd;

	// The datapath reports whether its pipeline may move and when the final result leaves.
	pasmu_pkg::stat_t stat;

	pasmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds both coefficient stores, the multiplier stage, the saturating
	// accumulator and the result register that parts it from the consumer.
	pasmu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
